// ===== src/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg: shared types and constants of the two-level thread scheduler
// Thread states, event and result codes, fixed field widths and reset values.
// ----------------------------------------------------------------------------
package tls_pkg;

  // Fixed field widths
  localparam int OP_W   = 3;
  localparam int EV_W   = 4;
  localparam int RT_W   = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_QUANTUM  = 1'b0;
  localparam logic [CIDX_W-1:0] REG_MAIN_RUN = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] QUANTUM_RST  = 16'd20;
  localparam logic [CFG_W-1:0] MAIN_RUN_RST = 16'd195;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUN     = 2'd2,
    ST_BLOCKED = 2'd3
  } status_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE    = 3'd0,
    OP_TICK      = 3'd1,
    OP_DISK_READ = 3'd2,
    OP_DISK_DONE = 3'd3,
    OP_EXIT      = 3'd4
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE      = 4'd0,
    EV_QUEUED    = 4'd1,
    EV_PREEMPT   = 4'd2,
    EV_FULL      = 4'd3,
    EV_SLICE     = 4'd4,
    EV_EJECTED   = 4'd5,
    EV_BLOCKED   = 4'd6,
    EV_UNBLK_Q   = 4'd7,
    EV_UNBLK_PRE = 4'd8,
    EV_FINISHED  = 4'd9,
    EV_WAKE      = 4'd10,
    EV_IDLE      = 4'd11,
    EV_DONE      = 4'd12
  } ev_t;

endpackage

// ===== src/two_level_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_level_thread_scheduler: shortest-first high queue, round-robin low queue
// Thread table, sorted high ready queue built as a row of cells, low ready
// FIFO and disk blocked FIFO; one result request per event request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : event requests. tuser = op; tdata = priority_req, run_ticks,
//           cache_hit (lowest bit first).
//   out_* : one result request per event. tuser = event_res; tdata =
//           subject_id, running_id, cpu_idle, all_done.
//   cfg_* : register writes (0 low-priority slice length, 1 run ticks of thread 0),
//           the user must write only while no event is in flight (not enforced).
// Timing: an accepted event is resolved combinationally; the result is
//   held in the output register from the next cycle. A new event is taken
//   only once the previous result has been handed over.
// The sorted insert and the head pop of the high queue are done by all
// cells of the row at once; on an insert each compares its key with the new one.
// Stall: while a result waits, in_tready stays low; nothing is lost.
// Reset: thread 0 runs with main_run_ticks remaining and a quantum slice,
//   all queues empty. Before the first event a config write reloads thread 0.
// ----------------------------------------------------------------------------
module two_level_thread_scheduler import tls_pkg::*; #(
  parameter int MAX_THREADS = 16,
  parameter int TICK_WIDTH  = 16,
  localparam int IDW        = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1,
  localparam int IN_W       = ((RT_W + 2 + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * IDW + 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // priority_req, run_ticks, cache_hit
  input  logic [OP_W-1:0]   in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // subject_id, running_id, cpu_idle, all_done
  output logic [EV_W-1:0]   out_tuser,  // event_res
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int TW = TICK_WIDTH;
  localparam int N  = MAX_THREADS;
  localparam int CW = $clog2(N + 1);

  function automatic logic [TW-1:0] fit(input logic [TW-1:0] q, input logic [TW-1:0] r);
    fit = (q < r) ? q : r;
  endfunction

  // Registers
  logic [TW-1:0]  quantum_r, main_run_r;
  status_t        st_r   [N];
  logic           pri_r  [N];
  logic [TW-1:0]  rem_r  [N];
  logic [TW-1:0]  slc_r  [N];
  status_t        st_nxt [N];
  logic           pri_nxt[N];
  logic [TW-1:0]  rem_nxt[N];
  logic [TW-1:0]  slc_nxt[N];
  logic [IDW-1:0] run_r, run_nxt;
  logic           has_r, has_nxt;
  logic           started_r;
  logic [CW-1:0]  hq_cnt_r;

  logic              out_valid_r;
  logic [EV_W-1:0]   res_ev_r;
  logic [IDW-1:0]    res_subj_r, res_run_r;
  logic              res_idle_r, res_done_r;

  // Input fields
  logic           accept;
  op_t            op;
  logic           prio_in, hit_in;
  logic [TW-1:0]  ticks_in;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r;
  assign op        = op_t'(in_tuser);
  assign prio_in   = in_tdata[0];
  assign ticks_in  = TW'(in_tdata[RT_W:1]);
  assign hit_in    = in_tdata[RT_W+1];

  // Queue controls
  logic           hq_ins, hq_pop;
  logic [IDW-1:0] hq_ins_id;
  logic [TW-1:0]  hq_ins_key;
  logic           lq_push, lq_pop, bq_push, bq_pop;
  logic [IDW-1:0] lq_push_id, bq_push_id, lq_pop_id, bq_pop_id;
  logic [CW-1:0]  lq_cnt, bq_cnt;

  // High queue cell row
  logic           hq_gt   [N];
  logic           hq_valid[N];
  logic [IDW-1:0] hq_id   [N];
  logic [TW-1:0]  hq_key  [N];

  for (genvar g = 0; g < N; g++) begin : g_hq
    tls_hq_cell #(.IDW(IDW), .TW(TW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins       (hq_ins),
      .ins_id    (hq_ins_id),
      .ins_key   (hq_ins_key),
      .pop       (hq_pop),
      .prev_gt   ((g == 0) ? 1'b0 : hq_gt[(g + N - 1) % N]),
      .prev_valid((g == 0) ? 1'b0 : hq_valid[(g + N - 1) % N]),
      .prev_id   (hq_id[(g + N - 1) % N]),
      .prev_key  (hq_key[(g + N - 1) % N]),
      .next_valid((g == N - 1) ? 1'b0 : hq_valid[(g + 1) % N]),
      .next_id   (hq_id[(g + 1) % N]),
      .next_key  (hq_key[(g + 1) % N]),
      .gt        (hq_gt[g]),
      .valid     (hq_valid[g]),
      .id        (hq_id[g]),
      .key       (hq_key[g])
    );
  end

  tls_fifo #(.DEPTH(N), .IDW(IDW), .CW(CW)) u_low (
    .clk(clk), .rst_n(rst_n), .push(lq_push), .push_id(lq_push_id),
    .pop(lq_pop), .pop_id(lq_pop_id), .cnt(lq_cnt)
  );

  tls_fifo #(.DEPTH(N), .IDW(IDW), .CW(CW)) u_blk (
    .clk(clk), .rst_n(rst_n), .push(bq_push), .push_id(bq_push_id),
    .pop(bq_pop), .pop_id(bq_pop_id), .cnt(bq_cnt)
  );

  // Free slot search
  logic           free_found;
  logic [IDW-1:0] free_id;
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (st_r[k] == ST_FREE) begin
        free_found = 1'b1;
        free_id    = IDW'(k);
      end
    end
  end

  // Event resolution
  ev_t            ev;
  logic [IDW-1:0] subj;
  logic           sched;
  logic [TW-1:0]  rem_dec, slc_dec;
  logic [CW-1:0]  hq_cnt_nxt, lq_cnt_nxt, bq_cnt_nxt;
  logic           done_nxt;
  logic [TW-1:0]  q_new, m_new;
  logic [IDW-1:0] r;

  assign r       = run_r;
  assign rem_dec = rem_r[r] - TW'(1);
  assign slc_dec = (slc_r[r] != '0) ? (slc_r[r] - TW'(1)) : '0;
  assign q_new   = (cfg_we && cfg_index == REG_QUANTUM)  ? TW'(cfg_data) : quantum_r;
  assign m_new   = (cfg_we && cfg_index == REG_MAIN_RUN) ? TW'(cfg_data) : main_run_r;

  always_comb begin
    st_nxt     = st_r;
    pri_nxt    = pri_r;
    rem_nxt    = rem_r;
    slc_nxt    = slc_r;
    run_nxt    = run_r;
    has_nxt    = has_r;
    ev         = EV_NONE;
    subj       = '0;
    sched      = 1'b0;
    hq_ins     = 1'b0;
    hq_ins_id  = '0;
    hq_ins_key = '0;
    hq_pop     = 1'b0;
    lq_push    = 1'b0;
    lq_push_id = '0;
    lq_pop     = 1'b0;
    bq_push    = 1'b0;
    bq_push_id = r;
    bq_pop     = 1'b0;

    if (accept) begin
      case (op)
        OP_CREATE: begin
          if (!free_found) begin
            ev = EV_FULL;
          end else begin
            pri_nxt[free_id] = prio_in;
            rem_nxt[free_id] = ticks_in;
            slc_nxt[free_id] = fit(quantum_r, ticks_in);
            subj             = free_id;
            if (has_r && prio_in && (!pri_r[r] || ticks_in < rem_r[r])) begin
              // park the runner, then run the new thread
              st_nxt[r] = ST_READY;
              if (pri_r[r]) begin
                hq_ins     = 1'b1;
                hq_ins_id  = r;
                hq_ins_key = rem_r[r];
              end else begin
                slc_nxt[r] = fit(quantum_r, rem_r[r]);
                lq_push    = 1'b1;
                lq_push_id = r;
              end
              st_nxt[free_id] = ST_RUN;
              run_nxt         = free_id;
              has_nxt         = 1'b1;
              ev              = EV_PREEMPT;
            end else begin
              st_nxt[free_id] = ST_READY;
              if (prio_in) begin
                hq_ins     = 1'b1;
                hq_ins_id  = free_id;
                hq_ins_key = ticks_in;
              end else begin
                lq_push    = 1'b1;
                lq_push_id = free_id;
              end
              ev = EV_QUEUED;
            end
          end
        end
        OP_TICK: begin
          if (!has_r) begin
            if (hq_cnt_r != '0 || lq_cnt != '0) begin
              sched = 1'b1;
              ev    = EV_WAKE;
            end else begin
              ev = EV_DONE;
            end
          end else if (rem_r[r] == '0) begin
            st_nxt[r] = ST_FREE;
            sched     = 1'b1;
            ev        = EV_EJECTED;
            subj      = r;
          end else if (pri_r[r]) begin
            rem_nxt[r] = rem_dec;
          end else begin
            rem_nxt[r] = rem_dec;
            slc_nxt[r] = slc_dec;
            if (rem_dec != '0 && slc_dec == '0) begin
              slc_nxt[r] = fit(quantum_r, rem_dec);
              st_nxt[r]  = ST_READY;
              lq_push    = 1'b1;
              lq_push_id = r;
              sched      = 1'b1;
              ev         = EV_SLICE;
              subj       = r;
            end
          end
        end
        OP_DISK_READ: begin
          if (!has_r) begin
            ev = EV_DONE;
          end else if (!hit_in) begin
            bq_push   = 1'b1;
            st_nxt[r] = ST_BLOCKED;
            sched     = 1'b1;
            ev        = EV_BLOCKED;
            subj      = r;
          end
        end
        OP_DISK_DONE: begin
          if (bq_cnt != '0) begin
            bq_pop = 1'b1;
            subj   = bq_pop_id;
            if (pri_r[bq_pop_id] && has_r &&
                (!pri_r[r] || rem_r[bq_pop_id] < rem_r[r])) begin
              st_nxt[r] = ST_READY;
              if (pri_r[r]) begin
                hq_ins     = 1'b1;
                hq_ins_id  = r;
                hq_ins_key = rem_r[r];
              end else begin
                slc_nxt[r] = fit(quantum_r, rem_r[r]);
                lq_push    = 1'b1;
                lq_push_id = r;
              end
              st_nxt[bq_pop_id] = ST_RUN;
              run_nxt           = bq_pop_id;
              has_nxt           = 1'b1;
              ev                = EV_UNBLK_PRE;
            end else begin
              st_nxt[bq_pop_id] = ST_READY;
              if (pri_r[bq_pop_id]) begin
                hq_ins     = 1'b1;
                hq_ins_id  = bq_pop_id;
                hq_ins_key = rem_r[bq_pop_id];
              end else begin
                lq_push    = 1'b1;
                lq_push_id = bq_pop_id;
              end
              ev = EV_UNBLK_Q;
            end
          end
        end
        OP_EXIT: begin
          if (!has_r) begin
            ev = EV_DONE;
          end else begin
            st_nxt[r] = ST_FREE;
            sched     = 1'b1;
            ev        = EV_FINISHED;
            subj      = r;
          end
        end
        default: ev = EV_NONE;
      endcase

      // dispatch: high head first, then low head
      if (sched) begin
        if (hq_cnt_r != '0) begin
          hq_pop            = 1'b1;
          run_nxt           = hq_id[0];
          has_nxt           = 1'b1;
          st_nxt[hq_id[0]]  = ST_RUN;
        end else if (lq_cnt != '0 || lq_push) begin
          lq_pop             = 1'b1;
          run_nxt            = lq_pop_id;
          has_nxt            = 1'b1;
          st_nxt[lq_pop_id]  = ST_RUN;
        end else begin
          run_nxt = '0;
          has_nxt = 1'b0;
        end
        if (ev == EV_WAKE) begin
          subj = run_nxt;
        end
      end
    end

    // before the first event a register write reloads thread 0
    if (cfg_we && !started_r) begin
      rem_nxt[0] = m_new;
      slc_nxt[0] = q_new;
    end
  end

  assign hq_cnt_nxt = hq_cnt_r + CW'(hq_ins) - CW'(hq_pop);
  assign lq_cnt_nxt = lq_cnt + CW'(lq_push) - CW'(lq_pop);
  assign bq_cnt_nxt = bq_cnt + CW'(bq_push) - CW'(bq_pop);
  assign done_nxt   = !has_nxt && hq_cnt_nxt == '0 && lq_cnt_nxt == '0 && bq_cnt_nxt == '0;

  // Scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r  <= TW'(QUANTUM_RST);
      main_run_r <= TW'(MAIN_RUN_RST);
      for (int k = 0; k < N; k++) begin
        st_r[k]  <= (k == 0) ? ST_RUN : ST_FREE;
        pri_r[k] <= 1'b0;
        rem_r[k] <= (k == 0) ? TW'(MAIN_RUN_RST) : '0;
        slc_r[k] <= (k == 0) ? TW'(QUANTUM_RST) : '0;
      end
      run_r     <= '0;
      has_r     <= 1'b1;
      started_r <= 1'b0;
      hq_cnt_r  <= '0;
    end else begin
      quantum_r  <= q_new;
      main_run_r <= m_new;
      st_r       <= st_nxt;
      pri_r      <= pri_nxt;
      rem_r      <= rem_nxt;
      slc_r      <= slc_nxt;
      run_r      <= run_nxt;
      has_r      <= has_nxt;
      hq_cnt_r   <= hq_cnt_nxt;
      if (accept) begin
        started_r <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (accept) begin
      res_ev_r   <= (ev == EV_DONE && !done_nxt) ? EV_IDLE : ev;
      res_subj_r <= subj;
      res_run_r  <= has_nxt ? run_nxt : '0;
      res_idle_r <= !has_nxt && !done_nxt;
      res_done_r <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_ev_r;
  assign out_tdata  = OUT_W'({res_done_r, res_idle_r, res_run_r, res_subj_r});

endmodule

// ===== src/tls_hq_cell.sv =====
// ----------------------------------------------------------------------------
// tls_hq_cell: one slot of the sorted high-priority ready queue
// Holds one thread id and its key; takes a new entry, its left neighbour's
// entry on an insert, or its right neighbour's entry on a pop.
// ----------------------------------------------------------------------------
module tls_hq_cell import tls_pkg::*; #(
  parameter int IDW = 4,
  parameter int TW  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ins,
  input  logic [IDW-1:0] ins_id,
  input  logic [TW-1:0]  ins_key,
  input  logic           pop,
  input  logic           prev_gt,
  input  logic           prev_valid,
  input  logic [IDW-1:0] prev_id,
  input  logic [TW-1:0]  prev_key,
  input  logic           next_valid,
  input  logic [IDW-1:0] next_id,
  input  logic [TW-1:0]  next_key,
  output logic           gt,
  output logic           valid,
  output logic [IDW-1:0] id,
  output logic [TW-1:0]  key
);

  logic           valid_r, valid_nxt;
  logic [IDW-1:0] id_r, id_nxt;
  logic [TW-1:0]  key_r, key_nxt;

  // empty slot counts as larger, so the insert point is found at the tail
  assign gt = !valid_r || (key_r > ins_key);

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    key_nxt   = key_r;
    if (ins && gt) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        id_nxt    = prev_id;
        key_nxt   = prev_key;
      end else begin
        valid_nxt = 1'b1;
        id_nxt    = ins_id;
        key_nxt   = ins_key;
      end
    end else if (pop) begin
      valid_nxt = next_valid;
      id_nxt    = next_id;
      key_nxt   = next_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;
  assign key   = key_r;

endmodule

// ===== src/tls_fifo.sv =====
// ----------------------------------------------------------------------------
// tls_fifo: shifting FIFO of thread ids
// Entries move one place towards the head on a pop; a push lands at the tail.
// Push and pop in one cycle on an empty FIFO pass the pushed id straight out.
// ----------------------------------------------------------------------------
module tls_fifo import tls_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IDW   = 4,
  parameter int CW    = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [IDW-1:0] push_id,
  input  logic           pop,
  output logic [IDW-1:0] pop_id,
  output logic [CW-1:0]  cnt
);

  logic [IDW-1:0] cell_r [DEPTH];
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  wr_pos;

  assign pop_id = (cnt_r == '0) ? push_id : cell_r[0];
  assign cnt    = cnt_r;
  assign wr_pos = pop ? (cnt_r - CW'(1)) : cnt_r;

  // shift towards the head, write the tail
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (push && (cnt_r != '0 || !pop) && (wr_pos == CW'(k))) begin
        cell_r[k] <= push_id;
      end else if (pop && k < DEPTH - 1) begin
        cell_r[k] <= cell_r[(k + 1) % DEPTH];
      end
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push && !pop && cnt_r < CW'(DEPTH)) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (pop && !push && cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== src/tls_checker.sv =====
// ----------------------------------------------------------------------------
// tls_checker: port-level checks of the thread scheduler
// Watches the stream and result ports of the top level over time.
// ----------------------------------------------------------------------------
module tls_checker import tls_pkg::*; #(
  parameter int IDW   = 4,
  parameter int OUT_W = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [EV_W-1:0]  out_tuser
);

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one event in flight: no new request while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  // idle and all-done never both set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2*IDW] && out_tdata[2*IDW+1]))
    else $error("idle and done both set");

  // every accepted request yields a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("missing result");

endmodule

bind two_level_thread_scheduler tls_checker #(.IDW(IDW), .OUT_W(OUT_W)) u_tls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== verif/two_level_thread_scheduler_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_thread_scheduler_check: result predictor and scoreboard
// Watches the event, result and register channels, keeps its own thread table
// and queues, works out one result per accepted request and compares every
// result request with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module two_level_thread_scheduler_check import tls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,   // priority_req, run_ticks, cache_hit
  input  logic [OP_W-1:0]   in_tuser,   // op
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       out_tdata,  // subject_id, running_id, cpu_idle, all_done
  input  logic [EV_W-1:0]   out_tuser,  // event_res
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                outstanding,
  output int                result_count
);

  localparam int NTH = 16;

  typedef struct packed {
    ev_t        ev;
    logic [3:0] subj;
    logic [3:0] run;
    logic       idle;
    logic       done;
  } sched_res_t;

  sched_res_t pending_q[$];

  // Shadow scheduler state
  logic [15:0] quantum, main_run;
  status_t     st   [NTH];
  logic        prio [NTH];
  logic [15:0] rem  [NTH];
  logic [15:0] slc  [NTH];
  logic [3:0]  hq [NTH];
  int          hq_cnt;
  logic [3:0]  lq [NTH];
  int          lq_head, lq_cnt;
  logic [3:0]  bq [NTH];
  int          bq_head, bq_cnt;
  logic [3:0]  runner;
  logic        has_runner;
  logic        started;

  function automatic logic [15:0] fit_slice(logic [15:0] r);
    return (quantum < r) ? quantum : r;
  endfunction

  task automatic reset_state();
    quantum = QUANTUM_RST;
    main_run = MAIN_RUN_RST;
    for (int i = 0; i < NTH; i++) begin
      st[i] = ST_FREE; prio[i] = 1'b0; rem[i] = '0; slc[i] = '0;
    end
    st[0] = ST_RUN;
    rem[0] = main_run;
    slc[0] = quantum;
    hq_cnt = 0; lq_head = 0; lq_cnt = 0; bq_head = 0; bq_cnt = 0;
    runner = '0; has_runner = 1'b1; started = 1'b0;
  endtask

  // Sorted insert: shortest remaining first, FIFO among equal keys
  task automatic high_insert(logic [3:0] id);
    int  pos;
    bit  found;
    if (hq_cnt >= NTH) return;
    pos = hq_cnt;
    found = 0;
    for (int i = 0; i < hq_cnt; i++)
      if (!found && rem[hq[i]] > rem[id]) begin
        pos = i; found = 1;
      end
    for (int i = hq_cnt; i > pos; i--) hq[i] = hq[i-1];
    hq[pos] = id;
    hq_cnt++;
    st[id] = ST_READY;
  endtask

  task automatic low_push(logic [3:0] id);
    if (lq_cnt >= NTH) return;
    lq[(lq_head + lq_cnt) % NTH] = id;
    lq_cnt++;
    st[id] = ST_READY;
  endtask

  task automatic run_thread(logic [3:0] id);
    runner = id; has_runner = 1'b1; st[id] = ST_RUN;
  endtask

  // Pick the next ready thread, high queue first
  task automatic dispatch_next();
    logic [3:0] id;
    if (hq_cnt > 0) begin
      id = hq[0];
      for (int i = 1; i < hq_cnt; i++) hq[i-1] = hq[i];
      hq_cnt--;
      run_thread(id);
    end else if (lq_cnt > 0) begin
      id = lq[lq_head];
      lq_head = (lq_head + 1) % NTH;
      lq_cnt--;
      run_thread(id);
    end else begin
      has_runner = 1'b0; runner = '0;
    end
  endtask

  task automatic park_runner();
    if (prio[runner]) high_insert(runner);
    else begin
      slc[runner] = fit_slice(rem[runner]);
      low_push(runner);
    end
  endtask

  task automatic schedule_event(input op_t op, input logic p, input logic [15:0] ticks,
                                input logic hit, output sched_res_t res);
    ev_t        ev;
    logic [3:0] subj, r, aux;
    int         i;
    logic       done;
    ev = EV_NONE; subj = '0;
    started = 1'b1;
    r = runner;
    case (op)
      OP_CREATE: begin
        i = 0;
        while (i < NTH && st[i] != ST_FREE) i++;
        if (i == NTH) ev = EV_FULL;
        else begin
          prio[i] = p; rem[i] = ticks; slc[i] = fit_slice(ticks);
          subj = i[3:0];
          if (has_runner && p && (!prio[r] || ticks < rem[r])) begin
            park_runner();
            run_thread(i[3:0]);
            ev = EV_PREEMPT;
          end else begin
            if (p) high_insert(i[3:0]); else low_push(i[3:0]);
            ev = EV_QUEUED;
          end
        end
      end
      OP_TICK: begin
        if (!has_runner) begin
          if (hq_cnt > 0 || lq_cnt > 0) begin
            dispatch_next(); ev = EV_WAKE; subj = runner;
          end else ev = EV_DONE;
        end else if (rem[r] == 0) begin
          st[r] = ST_FREE; dispatch_next(); ev = EV_EJECTED; subj = r;
        end else if (prio[r]) begin
          rem[r]--;
        end else begin
          rem[r]--;
          if (slc[r] > 0) slc[r]--;
          if (rem[r] != 0 && slc[r] == 0) begin
            slc[r] = fit_slice(rem[r]);
            low_push(r);
            dispatch_next();
            ev = EV_SLICE; subj = r;
          end
        end
      end
      OP_DISK_READ: begin
        if (!has_runner) ev = EV_DONE;
        else if (!hit) begin
          if (bq_cnt < NTH) begin
            bq[(bq_head + bq_cnt) % NTH] = r;
            bq_cnt++;
            st[r] = ST_BLOCKED;
          end
          dispatch_next(); ev = EV_BLOCKED; subj = r;
        end
      end
      OP_DISK_DONE: begin
        if (bq_cnt > 0) begin
          aux = bq[bq_head];
          bq_head = (bq_head + 1) % NTH;
          bq_cnt--;
          subj = aux;
          if (prio[aux] && has_runner && (!prio[r] || rem[aux] < rem[r])) begin
            park_runner(); run_thread(aux); ev = EV_UNBLK_PRE;
          end else begin
            if (prio[aux]) high_insert(aux); else low_push(aux);
            ev = EV_UNBLK_Q;
          end
        end
      end
      OP_EXIT: begin
        if (!has_runner) ev = EV_DONE;
        else begin
          st[r] = ST_FREE; dispatch_next(); ev = EV_FINISHED; subj = r;
        end
      end
      default: ;
    endcase
    done = !has_runner && hq_cnt == 0 && lq_cnt == 0 && bq_cnt == 0;
    if (ev == EV_DONE && !done) ev = EV_IDLE;
    res.ev = ev;
    res.subj = subj;
    res.run = has_runner ? runner : 4'd0;
    res.idle = !has_runner && !done;
    res.done = done;
  endtask

  always @(posedge clk) begin
    sched_res_t want, got;
    if (!rst_n) begin
      reset_state();
      pending_q.delete();
      fail_count <= 0;
      result_count <= 0;
      outstanding <= 0;
    end else begin
      // Register writes; thread 0 follows them until the first event
      if (cfg_we) begin
        if (cfg_index == REG_QUANTUM) quantum = cfg_data;
        else main_run = cfg_data;
        if (!started) begin
          rem[0] = main_run; slc[0] = quantum;
        end
      end
      // Result requests against the oldest prediction
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        got.ev = ev_t'(out_tuser);
        got.subj = out_tdata[3:0];
        got.run = out_tdata[7:4];
        got.idle = out_tdata[8];
        got.done = out_tdata[9];
        if (pending_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result ev=%0d subj=%0d run=%0d idle=%0b done=%0b",
                     $realtime, got.ev, got.subj, got.run, got.idle, got.done);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: exp ev=%0d subj=%0d run=%0d idle=%0b done=%0b",
                       $realtime, want.ev, want.subj, want.run, want.idle, want.done,
                       ", got ev=%0d subj=%0d run=%0d idle=%0b done=%0b",
                       got.ev, got.subj, got.run, got.idle, got.done);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Event requests
      if (in_tvalid && in_tready) begin
        schedule_event(op_t'(in_tuser), in_tdata[0], in_tdata[16:1], in_tdata[17], want);
        pending_q.push_back(want);
      end
      outstanding <= pending_q.size();
    end
  end

endmodule

// ===== verif/two_level_thread_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_thread_scheduler_test: stimulus and verdict for the scheduler
// Directed events over thread creation, preemption, slices, disk blocking and
// exit, then random event streams under several quantum settings with random
// gaps and stalls on both channels; the checker scores every result request.
// ----------------------------------------------------------------------------
module two_level_thread_scheduler_test;
  import tls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;   // priority_req, run_ticks, cache_hit
  logic [OP_W-1:0]   in_tuser = OP_TICK; // op
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;       // subject_id, running_id, cpu_idle, all_done
  logic [EV_W-1:0]   out_tuser;       // event_res
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_QUANTUM;
  logic [CFG_W-1:0]  cfg_data = '0;

  int  fail_count, outstanding, result_count;
  int  cycles = 0;
  bit  tx_gaps = 1, rx_stalls = 1, held_once = 0;
  int  settings = 0;

  always #2 clk = ~clk;

  two_level_thread_scheduler uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  two_level_thread_scheduler_check checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .result_count
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off to back the block up
  always begin
    int stall;
    @(negedge clk);
    if (!held_once && result_count >= 700) begin
      held_once = 1;
      out_tready <= 1'b0;
      repeat (400) @(negedge clk);
    end
    stall = rx_stalls ? $urandom_range(0, 8) : 0;
    if (stall > 0) begin
      out_tready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_tready <= 1'b1;
    do @(posedge clk); while (!(out_tvalid && out_tready));
  end

  // Called at a falling edge; returns at a falling edge
  task automatic send_event(op_t op, logic p, logic [15:0] ticks, logic hit);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, hit, ticks, p};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Let everything drain, then retune the quantum and the main-run register
  task automatic new_setting(logic [15:0] q, logic [15:0] m);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_QUANTUM, q);
    write_reg(REG_MAIN_RUN, m);
    settings++;
  endtask

  task automatic random_event();
    int          pick;
    logic [15:0] ticks;
    op_t         op;
    pick = $urandom_range(0, 99);
    if (pick < 25) op = OP_CREATE;
    else if (pick < 65) op = OP_TICK;
    else if (pick < 77) op = OP_DISK_READ;
    else if (pick < 89) op = OP_DISK_DONE;
    else op = OP_EXIT;
    pick = $urandom_range(0, 9);
    if (pick < 7) ticks = 16'($urandom_range(0, 12));
    else if (pick < 9) ticks = 16'($urandom_range(0, 300));
    else ticks = 16'($urandom);
    send_event(op, 1'($urandom_range(0, 1)), ticks, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Writes before the first event also reload thread 0
    write_reg(REG_MAIN_RUN, 16'd0);
    write_reg(REG_QUANTUM, 16'd2);
    write_reg(REG_MAIN_RUN, 16'd6);
    settings = 1;

    // Directed part
    send_event(OP_CREATE, 1'b0, 16'hFFFF, 1'b0);  // low queued
    send_event(OP_CREATE, 1'b1, 16'd0, 1'b0);     // high preempts low runner
    send_event(OP_CREATE, 1'b1, 16'd3, 1'b1);     // longer high only queued
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);       // high with nothing left ejected
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);
    send_event(OP_DISK_READ, 1'b0, 16'd0, 1'b1);  // cache hit
    send_event(OP_DISK_READ, 1'b0, 16'd0, 1'b0);  // blocks the runner
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);       // slice runs out
    send_event(OP_DISK_DONE, 1'b0, 16'd0, 1'b0);  // unblock
    send_event(OP_DISK_DONE, 1'b0, 16'd0, 1'b0);  // nothing blocked
    send_event(OP_EXIT, 1'b0, 16'd0, 1'b0);
    send_event(OP_EXIT, 1'b0, 16'd0, 1'b0);
    send_event(OP_EXIT, 1'b0, 16'd0, 1'b0);
    send_event(OP_EXIT, 1'b0, 16'd0, 1'b0);       // no runner left
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);
    send_event(OP_DISK_READ, 1'b0, 16'd0, 1'b0);
    send_event(OP_CREATE, 1'b1, 16'd1, 1'b0);     // queued with no runner
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);       // wake
    send_event(OP_DISK_READ, 1'b1, 16'd5, 1'b0);  // block, processor idle
    send_event(OP_DISK_DONE, 1'b0, 16'd0, 1'b0);  // unblock with no runner
    send_event(OP_TICK, 1'b0, 16'd0, 1'b0);
    for (int i = 0; i < 17; i++)                  // fill the table
      send_event(OP_CREATE, 1'(i % 2), 16'(i), 1'b0);

    // Random phases over several quantum settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: new_setting(16'd1, 16'd0);
        1: new_setting(16'hFFFF, 16'hFFFF);
        2: new_setting(16'd0, 16'd100);
        3: new_setting(16'd4, 16'h8000);
        default: new_setting(16'($urandom_range(1, 20)), 16'($urandom));
      endcase
      tx_gaps = (ph != 2);
      rx_stalls = (ph != 3);
      for (int n = 0; n < 400; n++) random_event();
    end

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Covered %0d results over %0d quantum settings,", result_count, settings);
    $display("with gaps, stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tls_pkg.sv
src/tls_hq_cell.sv
src/tls_fifo.sv
src/two_level_thread_scheduler.sv
src/tls_checker.sv
verif/two_level_thread_scheduler_check.sv
verif/two_level_thread_scheduler_test.sv
